// ===== src/lfsd_pkg.sv =====
// Shared types, widths and codes for the lowest-free-server dispatch block.
`default_nettype none
package lfsd_pkg;

  // Pool size and derived index width
  localparam int NUM_SERVERS = 16;
  localparam int IDX_W       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  // Field widths
  localparam int TIME_W  = 30;
  localparam int BUSY_W  = TIME_W + 1;
  localparam int AMT_W   = 30;
  localparam int TOTAL_W = 48;
  localparam int QIDX_W  = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Operation codes
  localparam logic OP_JOB  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Input item
  typedef struct packed {
    logic              operation;
    logic [TIME_W-1:0] arrival_time;
    logic [AMT_W-1:0]  job_amount;
    logic [TIME_W-1:0] service_duration;
    logic [QIDX_W-1:0] query_server;
  } in_t;

  // Result item
  typedef struct packed {
    logic               assigned;
    logic [QIDX_W-1:0]  server_index;
    logic [TOTAL_W-1:0] server_total;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input item
    logic sel;     // pick server, issue total read
    logic commit;  // write back total and busy-until
    logic emit;    // register the result item
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_job;
    logic found;
  } status_t;

endpackage
`default_nettype wire

// ===== src/lfsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lfsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== src/lfsd_ctrl.sv =====
// Controller state machine sequencing select, total read and write back.
`default_nettype none
module lfsd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire lfsd_pkg::status_t status,
  output lfsd_pkg::cmd_t        cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEL  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && start;
    cmd.sel    = (state_r == S_SEL);
    cmd.emit   = (state_r == S_UPD);
    cmd.commit = (state_r == S_UPD) && status.is_job && status.found;
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ===== src/lfsd_dp.sv =====
// Datapath: busy-until registers, idle search, total RAM and result register.
`default_nettype none
module lfsd_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lfsd_pkg::in_t    in_item,
  input  wire lfsd_pkg::cmd_t   cmd,
  output lfsd_pkg::status_t     status,
  output logic                  out_valid,
  output lfsd_pkg::out_t        out_item
);

  localparam int N = lfsd_pkg::NUM_SERVERS;
  localparam int W = lfsd_pkg::IDX_W;

  lfsd_pkg::in_t                  in_r;
  logic [lfsd_pkg::BUSY_W-1:0]    busy_r [N];
  logic [N-1:0]                   tot_vld_r;
  logic [W-1:0]                   sel_idx_r;
  logic                           found_r;
  logic                           q_ok_r;
  logic                           rd_vld_r;
  logic                           out_valid_r;
  lfsd_pkg::out_t                 out_r;

  logic [N-1:0]                   idle;
  logic [W-1:0]                   enc_idx;
  logic                           enc_found;
  logic                           q_ok;
  logic [W-1:0]                   q_addr;
  logic [W-1:0]                   raddr;
  logic                           is_read;
  logic [lfsd_pkg::TOTAL_W-1:0]   ram_rdata;
  logic [lfsd_pkg::TOTAL_W-1:0]   cur_total;
  logic [lfsd_pkg::TOTAL_W:0]     sum;
  logic [lfsd_pkg::TOTAL_W-1:0]   new_total;
  logic [lfsd_pkg::BUSY_W-1:0]    busy_end;

  // capture input item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
  end

  assign is_read = (in_r.operation == lfsd_pkg::OP_READ);

  // idle compare across all servers
  always_comb begin
    for (int i = 0; i < N; i++) begin
      idle[i] = (busy_r[i] <= {1'b0, in_r.arrival_time});
    end
  end

  // lowest-index priority encoder
  always_comb begin
    enc_idx   = '0;
    enc_found = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (idle[i]) begin
        enc_idx   = W'(i);
        enc_found = 1'b1;
      end
    end
  end

  // query address and range check
  assign q_ok   = (32'(in_r.query_server) < 32'(N));
  assign q_addr = W'(in_r.query_server);
  assign raddr  = is_read ? q_addr : enc_idx;

  // selection registers
  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      sel_idx_r <= enc_idx;
      found_r   <= enc_found;
      q_ok_r    <= q_ok;
      rd_vld_r  <= tot_vld_r[raddr] & (is_read ? q_ok : enc_found);
    end
  end

  // totals store; unwritten entries read as zero through the valid bits
  lfsd_ram #(
    .WIDTH (lfsd_pkg::TOTAL_W),
    .DEPTH (N)
  ) u_tot_ram (
    .clk     (clk),
    .we      (cmd.commit),
    .waddr   (sel_idx_r),
    .wdata   (new_total),
    .raddr   (raddr),
    .rdata_r (ram_rdata)
  );

  // saturating accumulate
  assign cur_total = rd_vld_r ? ram_rdata : '0;
  assign sum       = {1'b0, cur_total} + (lfsd_pkg::TOTAL_W + 1)'(in_r.job_amount);
  assign new_total = sum[lfsd_pkg::TOTAL_W] ? lfsd_pkg::TOTAL_MAX
                                            : sum[lfsd_pkg::TOTAL_W-1:0];
  assign busy_end  = {1'b0, in_r.arrival_time} +
                     lfsd_pkg::BUSY_W'(in_r.service_duration);

  // busy-until and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        busy_r[i] <= '0;
      end
      tot_vld_r <= '0;
    end else if (cmd.commit) begin
      busy_r[sel_idx_r]    <= busy_end;
      tot_vld_r[sel_idx_r] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (is_read) begin
        out_r.assigned     <= 1'b0;
        out_r.server_index <= in_r.query_server;
        out_r.server_total <= q_ok_r ? cur_total : '0;
      end else if (found_r) begin
        out_r.assigned     <= 1'b1;
        out_r.server_index <= lfsd_pkg::QIDX_W'(sel_idx_r);
        out_r.server_total <= new_total;
      end else begin
        out_r <= '0;
      end
    end
  end

  assign status.is_job = !is_read;
  assign status.found  = found_r;
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> tot_vld_r[$past(sel_idx_r)])
    else $error("written total not marked valid");

  a_commit_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (found_r && !is_read && cmd.emit))
    else $error("write back without an idle server");

  a_assigned_total: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !is_read && !found_r) |=> (out_r == '0))
    else $error("dropped job result not cleared");

endmodule
`default_nettype wire

// ===== src/lowest_free_server_dispatch.sv =====
// Top level of the lowest-free-server dispatch block.
//
// Usage:
//   Input channel: drive in_item and raise start; the item is taken at a rising
//   edge where start is high and busy is low. operation selects a job arrival
//   (server pick, total update) or a read of query_server's total.
//   Result channel: out_valid is high for exactly one cycle with out_item; the
//   receiver must take it then, there is no back pressure.
//   Sequencing: busy stays high through the select and update states that
//   follow acceptance, set by the read-modify-write of the totals RAM (select
//   for idle search and read address, update for the saturating add); the
//   result is then registered. A new item is not taken while busy is high.
//   A new item may be accepted in the same cycle a result is shown.
//   Reset (rst_n low, synchronous): all servers idle, all totals zero, no
//   result pending; totals clear at once through per-entry valid bits.
`default_nettype none
module lowest_free_server_dispatch (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire lfsd_pkg::in_t  in_item,
  output logic                out_valid,
  output lfsd_pkg::out_t      out_item
);

  lfsd_pkg::cmd_t    cmd;
  lfsd_pkg::status_t status;

  lfsd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  lfsd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the lowest-free-server dispatch block.
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1200;
  // random items in this window are offered with no start-low gaps between them
  localparam int STEADY_FIRST = 400;
  localparam int STEADY_LAST = 600;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT = 100000;

  localparam logic [lfsd_pkg::TIME_W-1:0] MAX_TIME = '1;
  localparam logic [lfsd_pkg::AMT_W-1:0] MAX_AMOUNT = '1;

  // One row of the directed table: item plus optional hand-written result
  typedef struct packed {
    lfsd_pkg::in_t  item;
    logic           typed;
    lfsd_pkg::out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  lfsd_pkg::in_t in_item = '0;
  logic busy;
  logic out_valid;
  lfsd_pkg::out_t out_item;

  // Dispatcher image: per-server busy-until and running total
  logic [lfsd_pkg::BUSY_W-1:0] srv_busy_until[lfsd_pkg::NUM_SERVERS];
  logic [lfsd_pkg::TOTAL_W-1:0] srv_total[lfsd_pkg::NUM_SERVERS];

  lfsd_pkg::out_t pending_results[$];
  stim_row_t directed[$];
  logic [lfsd_pkg::TIME_W-1:0] job_clock = '0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned n_placed = 0;
  int unsigned n_dropped = 0;
  int unsigned n_reads = 0;
  int unsigned n_saturated = 0;

  lowest_free_server_dispatch dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Item builders for the directed table
  function automatic lfsd_pkg::in_t job_item(logic [lfsd_pkg::TIME_W-1:0] t,
                                             logic [lfsd_pkg::AMT_W-1:0] amount,
                                             logic [lfsd_pkg::TIME_W-1:0] dur);
    lfsd_pkg::in_t it;
    it = '0;
    it.operation = lfsd_pkg::OP_JOB;
    it.arrival_time = t;
    it.job_amount = amount;
    it.service_duration = dur;
    return it;
  endfunction

  function automatic lfsd_pkg::in_t read_item(logic [lfsd_pkg::QIDX_W-1:0] srv);
    lfsd_pkg::in_t it;
    it = '0;
    it.operation = lfsd_pkg::OP_READ;
    it.query_server = srv;
    return it;
  endfunction

  function automatic stim_row_t row(lfsd_pkg::in_t it, logic typed, logic asg,
                                    logic [lfsd_pkg::QIDX_W-1:0] idx,
                                    logic [lfsd_pkg::TOTAL_W-1:0] tot);
    stim_row_t r;
    r.item = it;
    r.typed = typed;
    r.want.assigned = asg;
    r.want.server_index = idx;
    r.want.server_total = tot;
    return r;
  endfunction

  // Job: pick the lowest idle server, credit it, update the image; read: return the total
  function automatic lfsd_pkg::out_t predict_dispatch(lfsd_pkg::in_t it);
    lfsd_pkg::out_t r;
    logic found;
    logic [lfsd_pkg::TOTAL_W:0] sum;
    r = '0;
    found = 1'b0;
    if (it.operation == lfsd_pkg::OP_READ) begin
      r.server_index = it.query_server;
      if (int'(it.query_server) < lfsd_pkg::NUM_SERVERS)
        r.server_total = srv_total[it.query_server];
    end else begin
      for (int i = 0; i < lfsd_pkg::NUM_SERVERS; i++) begin
        if (!found && srv_busy_until[i] <= {1'b0, it.arrival_time}) begin
          found = 1'b1;
          sum = {1'b0, srv_total[i]} + (lfsd_pkg::TOTAL_W + 1)'(it.job_amount);
          srv_total[i] = sum[lfsd_pkg::TOTAL_W] ? lfsd_pkg::TOTAL_MAX
                                                : sum[lfsd_pkg::TOTAL_W-1:0];
          srv_busy_until[i] = {1'b0, it.arrival_time} + {1'b0, it.service_duration};
          r.assigned = 1'b1;
          r.server_index = lfsd_pkg::QIDX_W'(i);
          r.server_total = srv_total[i];
        end
      end
    end
    return r;
  endfunction

  // Random item: mostly rising arrival times, with restarts and jumps to the top
  function automatic lfsd_pkg::in_t random_item();
    lfsd_pkg::in_t it;
    int unsigned pick;
    it.operation = ($urandom_range(0, 99) < 20) ? lfsd_pkg::OP_READ : lfsd_pkg::OP_JOB;
    it.query_server = lfsd_pkg::QIDX_W'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    it.job_amount = (pick < 8) ? MAX_AMOUNT : (pick < 16) ? '0
                                            : lfsd_pkg::AMT_W'($urandom());
    if (it.operation == lfsd_pkg::OP_READ) begin
      // fields the block ignores still get noise
      it.arrival_time = lfsd_pkg::TIME_W'($urandom());
      it.service_duration = lfsd_pkg::TIME_W'($urandom());
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) job_clock = lfsd_pkg::TIME_W'($urandom_range(0, 1000));
      else if (pick < 5) job_clock = lfsd_pkg::TIME_W'($urandom());
      else if (pick < 7) job_clock = MAX_TIME;
      else if (job_clock > MAX_TIME - 20) job_clock = MAX_TIME;
      else job_clock = job_clock + lfsd_pkg::TIME_W'($urandom_range(0, 20));
      it.arrival_time = job_clock;
      // long stays end at or below MAX_TIME so the server frees up again
      pick = $urandom_range(0, 99);
      if (pick < 70) it.service_duration = lfsd_pkg::TIME_W'($urandom_range(0, 40));
      else if (pick < 96) it.service_duration = lfsd_pkg::TIME_W'($urandom_range(0, 300));
      else it.service_duration = lfsd_pkg::TIME_W'($urandom_range(0, MAX_TIME - job_clock));
    end
    return it;
  endfunction

  // Offer one item and hold it until taken; start stays high afterwards
  task automatic send_item(lfsd_pkg::in_t it, logic typed, lfsd_pkg::out_t want,
                           logic allow_gap);
    lfsd_pkg::out_t predicted;
    if (allow_gap) begin
      while ($urandom_range(0, 99) < 15) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_dispatch(it);
    pending_results.push_back(typed ? want : predicted);
    if (it.operation == lfsd_pkg::OP_READ) n_reads++;
    else if (predicted.assigned) n_placed++;
    else n_dropped++;
    if (predicted.server_total == lfsd_pkg::TOTAL_MAX) n_saturated++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    $display("%0t: %s expected %0h got %0h", $time, field, want, got);
  endtask

  // Result checker: one strobe, one expectation
  always @(posedge clk) begin : result_check
    lfsd_pkg::out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_field("unexpected result", '0, 64'(out_item));
      end else begin
        want = pending_results.pop_front();
        if (out_item.assigned !== want.assigned)
          report_field("assigned", 64'(want.assigned), 64'(out_item.assigned));
        if (out_item.server_index !== want.server_index)
          report_field("server_index", 64'(want.server_index), 64'(out_item.server_index));
        if (out_item.server_total !== want.server_total)
          report_field("server_total", 64'(want.server_total), 64'(out_item.server_total));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < lfsd_pkg::NUM_SERVERS; i++) begin
      srv_busy_until[i] = '0;
      srv_total[i] = '0;
    end

    // Directed table: extremes, fill the pool, drop, busy-until past 30 bits, time going back
    directed.push_back(row(read_item(4'd15), 1'b1, 1'b0, 4'd15, '0));
    directed.push_back(row(job_item('0, MAX_AMOUNT, '0), 1'b1, 1'b1, 4'd0,
                           lfsd_pkg::TOTAL_W'(MAX_AMOUNT)));
    directed.push_back(row(job_item('0, MAX_AMOUNT, '0), 1'b0, 1'b0, '0, '0));
    directed.push_back(row(job_item(30'd5, 30'd1, 30'd10), 1'b0, 1'b0, '0, '0));
    for (int i = 1; i < lfsd_pkg::NUM_SERVERS; i++)
      directed.push_back(row(job_item(30'd6, lfsd_pkg::AMT_W'(i * 1000 + 7), 30'd100),
                             1'b0, 1'b0, '0, '0));
    directed.push_back(row(job_item(30'd7, 30'd9, 30'd1), 1'b1, 1'b0, 4'd0, '0));
    directed.push_back(row(read_item(4'd0), 1'b0, 1'b0, '0, '0));
    directed.push_back(row(read_item(4'd15), 1'b0, 1'b0, '0, '0));
    directed.push_back(row(job_item(MAX_TIME, 30'd3, MAX_TIME), 1'b0, 1'b0, '0, '0));
    directed.push_back(row(job_item('0, 30'd4, '0), 1'b1, 1'b0, 4'd0, '0));
    directed.push_back(row(read_item(4'd1), 1'b0, 1'b0, '0, '0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_item(directed[i].item, directed[i].typed, directed[i].want, 1'b1);
    drain_results();

    // Random traffic, with a stretch without gaps and one full drain midway
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_item(random_item(), 1'b0, '0, !(n >= STEADY_FIRST && n < STEADY_LAST));
      if (n == RANDOM_ITEMS / 2) drain_results();
    end

    // Read back every server's total
    for (int q = 0; q < lfsd_pkg::NUM_SERVERS; q++)
      send_item(read_item(lfsd_pkg::QIDX_W'(q)), 1'b0, '0, 1'b1);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d jobs placed, %0d jobs dropped, %0d reads", n_placed, n_dropped,
             n_reads);
    $display("%0d results at the saturated total; %0d field mismatches", n_saturated,
             mismatches);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lfsd_pkg.sv
src/lfsd_ram.sv
src/lfsd_ctrl.sv
src/lfsd_dp.sv
src/lowest_free_server_dispatch.sv
sim/testbench.sv
